FILE: rtl/kcdl_pkg.sv
// Shared types, constants and helpers for the keypad code door lock.
package kcdl_pkg;

   localparam int TICK_W = 24;
   localparam int KEY_W = 4;
   localparam int PHASE_W = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TICK_W-1:0] PULSE_TICKS_RESET = 24'd1000;
   localparam logic [TICK_W-1:0] HOLD_TICKS_RESET = 24'd10000;

   localparam logic CSR_PULSE_TICKS = 1'b0;
   localparam logic CSR_HOLD_TICKS = 1'b1;

   localparam logic ACTION_KEY = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic [KEY_W-1:0] KEY_ZERO = 4'd0;

   localparam logic [PHASE_W-1:0] LOCK_PHASE_ENROLL = 3'd0;
   localparam logic [PHASE_W-1:0] LOCK_PHASE_ENTRY = 3'd1;
   localparam logic [PHASE_W-1:0] LOCK_PHASE_PASS = 3'd2;
   localparam logic [PHASE_W-1:0] LOCK_PHASE_FAIL = 3'd3;
   localparam logic [PHASE_W-1:0] LOCK_PHASE_CLEAR = 3'd4;
   localparam logic [PHASE_W-1:0] LOCK_PHASE_FLASH = 3'd5;

   typedef enum logic [5:0] {
      PH_ENROLL = 6'b000001,
      PH_ENTRY  = 6'b000010,
      PH_PASS   = 6'b000100,
      PH_FAIL   = 6'b001000,
      PH_CLEAR  = 6'b010000,
      PH_FLASH  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] pulse_ticks;
      logic [TICK_W-1:0] hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic               solenoid_on;
      logic               enroll_led;
      logic               entry_led;
      logic               pass_led;
      logic               fail_led;
      logic               busy_flag;
      logic               key_dropped;
      logic [PHASE_W-1:0] lock_phase;
   } rsp_type;

   function automatic logic [PHASE_W-1:0] phase_code(input phase_type ph);
      logic [PHASE_W-1:0] code;
      unique case (ph)
         PH_ENROLL: code = LOCK_PHASE_ENROLL;
         PH_ENTRY:  code = LOCK_PHASE_ENTRY;
         PH_PASS:   code = LOCK_PHASE_PASS;
         PH_FAIL:   code = LOCK_PHASE_FAIL;
         PH_CLEAR:  code = LOCK_PHASE_CLEAR;
         PH_FLASH:  code = LOCK_PHASE_FLASH;
         default:   code = LOCK_PHASE_ENROLL;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/kcdl_if.sv
// Valid/ready channel interfaces for key/tick beats and lock status beats.
interface kcdl_req_if;
   import kcdl_pkg::*;

   logic             valid;
   logic             ready;
   logic             action;
   logic [KEY_W-1:0] key_value;

   modport source (output valid, output action, output key_value, input ready);
   modport sink (input valid, input action, input key_value, output ready);
endinterface

interface kcdl_rsp_if;
   import kcdl_pkg::*;

   logic               valid;
   logic               ready;
   logic               solenoid_on;
   logic               enroll_led;
   logic               entry_led;
   logic               pass_led;
   logic               fail_led;
   logic               busy_flag;
   logic               key_dropped;
   logic [PHASE_W-1:0] lock_phase;

   modport source (
      output valid, output solenoid_on, output enroll_led, output entry_led,
      output pass_led, output fail_led, output busy_flag, output key_dropped,
      output lock_phase, input ready
   );
   modport sink (
      input valid, input solenoid_on, input enroll_led, input entry_led,
      input pass_led, input fail_led, input busy_flag, input key_dropped,
      input lock_phase, output ready
   );
endinterface

FILE: rtl/kcdl_fsm.sv
// Lock state machine: code store, attempt flags, tick and blink counters.
module kcdl_fsm #(
   parameter int CODE_LENGTH = 6,
   parameter int BLINK_COUNT = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    action,
   input  logic [kcdl_pkg::KEY_W-1:0] key_value,
   input  kcdl_pkg::cfg_type       cfg,
   output kcdl_pkg::rsp_type       rsp
);
   import kcdl_pkg::*;

   localparam int PW = $clog2(CODE_LENGTH + 1);
   localparam int IW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam int BW = $clog2(2 * BLINK_COUNT + 3);
   localparam logic [PW-1:0] CODE_LEN = PW'(CODE_LENGTH);
   localparam logic [BW-1:0] LAST_HALF = BW'(2 * BLINK_COUNT);
   localparam logic [BW-1:0] HOLD_END = BW'(2 * BLINK_COUNT + 1);

   phase_type         phase_ff, phase_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic              match_ff, match_in;
   logic              zero_ff, zero_in;
   logic              set_ff, set_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [BW-1:0]     blink_ff, blink_in;
   logic [KEY_W-1:0]  code_ff [CODE_LENGTH];

   logic              code_we;
   logic              dropped;
   logic              pos_open;
   logic [TICK_W-1:0] tick_inc;
   logic [TICK_W-1:0] target;
   logic              done;
   logic [BW-1:0]     blink_inc;
   logic              blink_on;

   assign pos_open = pos_ff < CODE_LEN;
   assign tick_inc = tick_ff + TICK_W'(1);
   assign target = (phase_ff == PH_PASS && blink_ff > LAST_HALF) ? cfg.hold_ticks
                                                                 : cfg.pulse_ticks;
   assign done = tick_inc >= target;
   assign blink_inc = blink_ff + BW'(1);

   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      match_in = match_ff;
      zero_in = zero_ff;
      set_in = set_ff;
      tick_in = tick_ff;
      blink_in = blink_ff;
      code_we = 1'b0;
      dropped = 1'b0;
      if (action == ACTION_TICK) begin
         unique case (phase_ff)
            PH_FLASH: begin
               tick_in = done ? '0 : tick_inc;
               if (done) begin
                  if (pos_open) begin
                     phase_in = set_ff ? PH_ENTRY : PH_ENROLL;
                  end else begin
                     pos_in = '0;
                     match_in = 1'b1;
                     zero_in = 1'b1;
                     blink_in = '0;
                     if (!set_ff) begin
                        set_in = 1'b1;
                        phase_in = PH_ENTRY;
                     end else if (zero_ff) begin
                        phase_in = PH_CLEAR;
                     end else if (match_ff) begin
                        phase_in = PH_PASS;
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end
               end
            end
            PH_PASS, PH_FAIL: begin
               tick_in = done ? '0 : tick_inc;
               if (done) begin
                  blink_in = blink_inc;
                  if ((phase_ff == PH_FAIL && blink_inc > LAST_HALF) ||
                      blink_inc > HOLD_END) begin
                     pos_in = '0;
                     match_in = 1'b1;
                     zero_in = 1'b1;
                     blink_in = '0;
                     phase_in = PH_ENTRY;
                  end
               end
            end
            PH_CLEAR: begin
               tick_in = done ? '0 : tick_inc;
               if (done) begin
                  set_in = 1'b0;
                  pos_in = '0;
                  match_in = 1'b1;
                  zero_in = 1'b1;
                  blink_in = '0;
                  phase_in = PH_ENROLL;
               end
            end
            default: begin
            end
         endcase
      end else begin
         unique case (phase_ff)
            PH_ENROLL: begin
               code_we = pos_open;
               pos_in = pos_ff + PW'(1);
               tick_in = '0;
               phase_in = PH_FLASH;
            end
            PH_ENTRY: begin
               if (pos_open && code_ff[pos_ff[IW-1:0]] != key_value) begin
                  match_in = 1'b0;
               end
               if (key_value != KEY_ZERO) begin
                  zero_in = 1'b0;
               end
               pos_in = pos_ff + PW'(1);
               tick_in = '0;
               phase_in = PH_FLASH;
            end
            default: begin
               dropped = 1'b1;
            end
         endcase
      end
   end

   assign blink_on = blink_in >= BW'(1) && blink_in <= LAST_HALF && blink_in[0];

   always_comb begin
      rsp.solenoid_on = phase_in == PH_PASS && blink_in >= BW'(1);
      rsp.enroll_led = set_in || phase_in == PH_FLASH;
      rsp.entry_led = phase_in == PH_FLASH && set_in;
      rsp.pass_led = phase_in == PH_PASS && blink_on;
      rsp.fail_led = phase_in == PH_FAIL && blink_on;
      rsp.busy_flag = phase_in == PH_PASS || phase_in == PH_FAIL ||
                      phase_in == PH_CLEAR || phase_in == PH_FLASH;
      rsp.key_dropped = dropped;
      rsp.lock_phase = phase_code(phase_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ENROLL;
         pos_ff <= '0;
         match_ff <= 1'b1;
         zero_ff <= 1'b1;
         set_ff <= 1'b0;
         tick_ff <= '0;
         blink_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         match_ff <= match_in;
         zero_ff <= zero_in;
         set_ff <= set_in;
         tick_ff <= tick_in;
         blink_ff <= blink_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && action == ACTION_KEY && code_we) begin
         code_ff[pos_ff[IW-1:0]] <= key_value;
      end
   end

endmodule

FILE: rtl/keypad_code_door_lock.sv
// Keypad code door lock: one beat a cycle unless the result buffer is full; results are registered.
// Each key or tick beat is handled in the cycle it is accepted and its status
// beat is registered in the result buffer and presented from there. A two-entry
// result buffer lets one more beat in while a status beat waits, so the lock
// sustains one beat per cycle when the sink keeps up. Timing registers are
// written over APB at 0x0 (pulse_ticks) and 0x4 (hold_ticks); write them only
// while the lock is quiet.
module keypad_code_door_lock #(
   parameter int CODE_LENGTH = 6,
   parameter int BLINK_COUNT = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   kcdl_req_if.sink                        req_chan,
   kcdl_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [kcdl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [kcdl_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [kcdl_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import kcdl_pkg::*;

   cfg_type cfg_ff, cfg_in;
   rsp_type next_rsp;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    push;
   logic    take;
   logic    csr_write;

   // configuration
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (paddr[2])
            CSR_PULSE_TICKS: cfg_in.pulse_ticks = pwdata[TICK_W-1:0];
            CSR_HOLD_TICKS:  cfg_in.hold_ticks = pwdata[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_PULSE_TICKS: prdata = CSR_DATA_W'(cfg_ff.pulse_ticks);
         CSR_HOLD_TICKS:  prdata = CSR_DATA_W'(cfg_ff.hold_ticks);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_ticks <= PULSE_TICKS_RESET;
         cfg_ff.hold_ticks <= HOLD_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // lock core
   assign req_chan.ready = !skid_valid_ff;
   assign push = req_chan.valid && !skid_valid_ff;
   assign take = main_valid_ff && rsp_chan.ready;

   kcdl_fsm #(
      .CODE_LENGTH(CODE_LENGTH),
      .BLINK_COUNT(BLINK_COUNT)
   ) u_fsm (
      .clock(clock),
      .reset(reset),
      .step(push),
      .action(req_chan.action),
      .key_value(req_chan.key_value),
      .cfg(cfg_ff),
      .rsp(next_rsp)
   );

   // result buffer
   always_comb begin
      main_in = main_ff;
      skid_in = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_in = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || take) begin
            main_in = next_rsp;
            main_valid_in = 1'b1;
         end else begin
            skid_in = next_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid = main_valid_ff;
   assign rsp_chan.solenoid_on = main_ff.solenoid_on;
   assign rsp_chan.enroll_led = main_ff.enroll_led;
   assign rsp_chan.entry_led = main_ff.entry_led;
   assign rsp_chan.pass_led = main_ff.pass_led;
   assign rsp_chan.fail_led = main_ff.fail_led;
   assign rsp_chan.busy_flag = main_ff.busy_flag;
   assign rsp_chan.key_dropped = main_ff.key_dropped;
   assign rsp_chan.lock_phase = main_ff.lock_phase;

endmodule

FILE: rtl/kcdl_checker.sv
// Port-level checks for the keypad code door lock, bound to the top level.
module kcdl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [kcdl_pkg::PHASE_W-1:0]  rsp_lock_phase,
   input logic                          rsp_key_dropped
);
   import kcdl_pkg::*;

   // buffer is empty right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

   // a status beat is pending in the cycle after every accepted beat
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("no status beat after accepted input beat");

   // an empty result register always leaves room
   a_room_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no pending status beat");

   // stalled status beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_lock_phase) && $stable(rsp_key_dropped)))
      else $error("stalled status beat changed");

endmodule

bind keypad_code_door_lock kcdl_checker u_kcdl_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_lock_phase(rsp_chan.lock_phase),
   .rsp_key_dropped(rsp_chan.key_dropped)
);
